/* rtl/core/pvi_pkg.sv */
// ----------------------------------------------------------------------------
// pvi_pkg
// Shared types, codes and helpers for the particle verlet integrator.
// ----------------------------------------------------------------------------
package pvi_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned NumDim = 3;

  // request codes carried by req_type
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_SETACC = 2'd1,
    REQ_STEP   = 2'd2
  } req_type_e;

  // per-lane operation for one cycle
  typedef enum logic [2:0] {
    LOP_IDLE,
    LOP_LOAD,
    LOP_SETACC,
    LOP_A1,
    LOP_A2,
    LOP_VEL_HALF,
    LOP_POS,
    LOP_VEL_FULL
  } lane_op_e;

  // clamp a wide signed sum to the signed 32-bit range
  function automatic logic signed [WordW-1:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[WordW-1:0];
    end
  endfunction

endpackage

/* rtl/core/particle_verlet_integrator.sv */
// ----------------------------------------------------------------------------
// particle_verlet_integrator
// Velocity-verlet integrator for one particle, one lane per dimension.
// ----------------------------------------------------------------------------
// Usage: requests enter on the input channel (in_valid_i / in_stall_o), one
// beat per request; every request gives exactly one result beat on the
// output channel (out_valid_o / out_stall_i) carrying the frequency and the
// positions and velocities after the request.
// One request is worked at a time. A load or unused code goes from the
// execute state straight to the done state, an integrate step runs five
// multiply steps in every lane in parallel, and a set-acceleration request
// waits on the frequency unit: eight partial products on a 32x32 and a
// 32x31 multiplier and one to five word scans. The next request is taken in
// the idle state after the result is loaded.
// While a result waits under out_stall_i, the next request may be accepted
// and worked; its result waits until the held beat is taken.
// Reset clears all dimension state to zero and empties the output register.
// ----------------------------------------------------------------------------
module particle_verlet_integrator
  import pvi_pkg::*;
#(
  parameter int unsigned DIMENSIONS   = 3,
  parameter int unsigned LOG_FREQ_MAX = 8,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [1:0]         dim_index_i,
  input  logic signed [31:0] init_position_i,
  input  logic signed [31:0] init_velocity_i,
  input  logic signed [31:0] acc_x_i,
  input  logic signed [31:0] acc_y_i,
  input  logic signed [31:0] acc_z_i,
  input  logic [30:0]        time_step_i,
  input  logic [16:0]        substep_progress_i,
  input  logic [16:0]        substep_length_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [8:0]         refresh_rate_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_SUM, ST_FREQ, ST_DONE} state_e;

  state_e   state_q;
  lane_op_e step_q;
  logic     out_valid_q;
  logic [8:0] freq_out_q;
  logic signed [WordW-1:0] pos_out_q [NumDim];
  logic signed [WordW-1:0] vel_out_q [NumDim];

  // request registers
  logic [1:0]              req_q, dim_q;
  logic signed [WordW-1:0] ipos_q, ivel_q;
  logic signed [WordW-1:0] acc_in_q [NumDim];
  logic [30:0]             dt_q;
  logic [16:0]             prog_q, len_q;

  logic signed [WordW-1:0] lane_pos [NumDim];
  logic signed [WordW-1:0] lane_vel [NumDim];
  logic [63:0]             lane_sq  [NumDim];
  lane_op_e                lane_op  [NumDim];

  logic        accept, out_free, freq_start, freq_done;
  logic [63:0] sum_sq;
  logic [8:0]  freq_res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign freq_start = (state_q == ST_SUM);

  // capture the request beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q       <= req_type_i;
      dim_q       <= dim_index_i;
      ipos_q      <= init_position_i;
      ivel_q      <= init_velocity_i;
      acc_in_q[0] <= acc_x_i;
      acc_in_q[1] <= acc_y_i;
      acc_in_q[2] <= acc_z_i;
      dt_q        <= time_step_i;
      prog_q      <= substep_progress_i;
      len_q       <= substep_length_i;
    end
  end

  // lane operation decode
  always_comb begin
    for (int g = 0; g < NumDim; g++) begin
      lane_op[g] = LOP_IDLE;
      if (state_q == ST_EXEC) begin
        case (req_q)
          REQ_LOAD:   if (dim_q == 2'(g)) lane_op[g] = LOP_LOAD;
          REQ_SETACC: lane_op[g] = LOP_SETACC;
          REQ_STEP:   lane_op[g] = step_q;
          default: ;
        endcase
      end
    end
  end

  // one lane per dimension; unused dimensions read as zero
  for (genvar g = 0; g < NumDim; g++) begin : g_lane
    if (g < DIMENSIONS) begin : g_on
      pvi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
        .clk_i,
        .rst_ni,
        .op_i       (lane_op[g]),
        .init_pos_i (ipos_q),
        .init_vel_i (ivel_q),
        .acc_in_i   (acc_in_q[g]),
        .dt_i       (dt_q),
        .prog_i     (prog_q),
        .len_i      (len_q),
        .pos_o      (lane_pos[g]),
        .vel_o      (lane_vel[g]),
        .sq_o       (lane_sq[g])
      );
    end else begin : g_off
      assign lane_pos[g] = '0;
      assign lane_vel[g] = '0;
      assign lane_sq[g]  = '0;
    end
  end

  // merge: sum of squared components
  always_comb begin
    sum_sq = '0;
    for (int g = 0; g < NumDim; g++) begin
      sum_sq = sum_sq + lane_sq[g];
    end
  end

  pvi_freq #(
    .FRAC_BITS    (FRAC_BITS),
    .LOG_FREQ_MAX (LOG_FREQ_MAX)
  ) u_freq (
    .clk_i,
    .rst_ni,
    .start_i (freq_start),
    .sum_i   (sum_sq),
    .dt_i    (dt_q),
    .done_o  (freq_done),
    .freq_o  (freq_res)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= LOP_A1;
      out_valid_q <= 1'b0;
      freq_out_q  <= '0;
    end else begin
      // load a finished result, or drop a beat that was taken
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        freq_out_q  <= (req_q == REQ_SETACC) ? freq_res : '0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
            step_q  <= LOP_A1;
          end
        end
        ST_EXEC: begin
          case (req_q)
            REQ_SETACC: state_q <= ST_SUM;
            REQ_STEP: begin
              case (step_q)
                LOP_A1:       step_q <= LOP_A2;
                LOP_A2:       step_q <= LOP_VEL_HALF;
                LOP_VEL_HALF: step_q <= LOP_POS;
                LOP_POS:      step_q <= LOP_VEL_FULL;
                default:      state_q <= ST_DONE;
              endcase
            end
            default: state_q <= ST_DONE;
          endcase
        end
        ST_SUM:  state_q <= ST_FREQ;
        ST_FREQ: if (freq_done) state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      pos_out_q <= lane_pos;
      vel_out_q <= lane_vel;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign refresh_rate_o = freq_out_q;
  assign pos_x_o        = pos_out_q[0];
  assign pos_y_o        = pos_out_q[1];
  assign pos_z_o        = pos_out_q[2];
  assign vel_x_o        = vel_out_q[0];
  assign vel_y_o        = vel_out_q[1];
  assign vel_z_o        = vel_out_q[2];

  // an accepted beat blocks the input until its result is queued
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> in_stall_o)
    else $error("input not stalled after accepting a request");

  // the frequency unit only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni) freq_done |-> state_q == ST_FREQ)
    else $error("frequency result outside the wait state");

  // a reported frequency is zero or a single power of two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(refresh_rate_o))
    else $error("refresh rate is not a power of two");

endmodule

/* rtl/core/pvi_lane.sv */
// ----------------------------------------------------------------------------
// pvi_lane
// One dimension: holds position, velocity, acceleration and delta, and runs
// one multiply-shift-add-saturate step per cycle under control of the top.
// ----------------------------------------------------------------------------
module pvi_lane
  import pvi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_op_e                op_i,
  input  logic signed [WordW-1:0] init_pos_i,
  input  logic signed [WordW-1:0] init_vel_i,
  input  logic signed [WordW-1:0] acc_in_i,
  input  logic [30:0]             dt_i,
  input  logic [16:0]             prog_i,
  input  logic [16:0]             len_i,
  output logic signed [WordW-1:0] pos_o,
  output logic signed [WordW-1:0] vel_o,
  output logic [63:0]             sq_o
);

  logic signed [WordW-1:0] pos_q, vel_q, acc_q, dlt_q;
  logic signed [WordW-1:0] a1_q, a2_q, v_q;
  logic [63:0]             sq_q;

  logic signed [WordW-1:0] mul_a, mul_b, base;
  logic signed [63:0]      prod, shifted;
  logic                    half;
  logic signed [WordW-1:0] res;
  logic signed [WordW-1:0] acc_new, dlt_new;

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = dlt_q;
    mul_b = $signed({15'b0, prog_i});
    base  = acc_q;
    half  = 1'b0;
    case (op_i)
      LOP_A2: begin
        mul_b = $signed({15'b0, len_i});
        base  = a1_q;
      end
      LOP_VEL_HALF: begin
        mul_a = a1_q;
        mul_b = $signed({1'b0, dt_i});
        base  = vel_q;
        half  = 1'b1;
      end
      LOP_POS: begin
        mul_a = v_q;
        mul_b = $signed({1'b0, dt_i});
        base  = pos_q;
      end
      LOP_VEL_FULL: begin
        mul_a = a2_q;
        mul_b = $signed({1'b0, dt_i});
        base  = v_q;
        half  = 1'b1;
      end
      LOP_SETACC: begin
        mul_a = acc_in_i;
        mul_b = acc_in_i;
      end
      default: ;
    endcase
  end

  // multiply, floor shift, add and saturate
  always_comb begin
    prod    = mul_a * mul_b;
    shifted = half ? (prod >>> (FRAC_BITS + 1)) : (prod >>> FRAC_BITS);
    res     = sat32(65'(base) + 65'(shifted));
    acc_new = sat32(65'(acc_q) + 65'(dlt_q));
    dlt_new = sat32(65'(acc_in_i) - 65'(acc_new));
  end

  // dimension state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vel_q <= '0;
      acc_q <= '0;
      dlt_q <= '0;
    end else begin
      case (op_i)
        LOP_LOAD: begin
          pos_q <= init_pos_i;
          vel_q <= init_vel_i;
        end
        LOP_SETACC: begin
          acc_q <= acc_new;
          dlt_q <= dlt_new;
        end
        LOP_POS:      pos_q <= res;
        LOP_VEL_FULL: vel_q <= res;
        default: ;
      endcase
    end
  end

  // step temporaries
  always_ff @(posedge clk_i) begin
    case (op_i)
      LOP_A1:       a1_q <= res;
      LOP_A2:       a2_q <= res;
      LOP_VEL_HALF: v_q  <= res;
      LOP_SETACC:   sq_q <= prod;
      default: ;
    endcase
  end

  assign pos_o = pos_q;
  assign vel_o = vel_q;
  assign sq_o  = sq_q;

endmodule

/* rtl/core/pvi_freq.sv */
// ----------------------------------------------------------------------------
// pvi_freq
// Update frequency estimate: forms q = s^2 * dt exactly with a 32x32 and
// a 32x31 multiplier, scans q for its leading one a word a cycle.
// ----------------------------------------------------------------------------
module pvi_freq
  import pvi_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned LOG_FREQ_MAX = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] sum_i,
  input  logic [30:0] dt_i,
  output logic        done_o,
  output logic [8:0]  freq_o
);

  typedef enum logic [2:0] {F_IDLE, F_SQ, F_QD, F_SCAN, F_OUT} fphase_e;

  fphase_e          phase_q;
  logic [2:0]       cnt_q;
  logic [1:0][31:0] s_q;
  logic [30:0]      dt_q;
  logic [3:0][31:0] sq_q;
  logic [4:0][31:0] q_q;
  logic             pw_q, zero_q, done_q;
  logic [7:0]       p_q;
  logic [8:0]       freq_q;

  logic [63:0]  pp_s;
  logic [127:0] pp_s_sh;
  logic [62:0]  pp_d;
  logic [159:0] pp_d_sh;
  logic [31:0]  word;
  logic [4:0]   msb;
  logic signed [10:0] e, de, k, lg;
  logic [8:0]   freq_new;

  // partial products and word scan
  always_comb begin
    pp_s = s_q[cnt_q[1]] * s_q[cnt_q[0]];
    case (2'(cnt_q[1]) + 2'(cnt_q[0]))
      2'd0:    pp_s_sh = 128'(pp_s);
      2'd1:    pp_s_sh = 128'(pp_s) << 32;
      default: pp_s_sh = 128'(pp_s) << 64;
    endcase
    pp_d    = sq_q[cnt_q[1:0]] * dt_q;
    pp_d_sh = 160'(pp_d) << {cnt_q[1:0], 5'b0};
    word    = q_q[cnt_q];
    msb     = '0;
    for (int b = 0; b < 32; b++) begin
      if (word[b]) msb = 5'(b);
    end
  end

  // exponent to frequency
  always_comb begin
    e  = $signed({3'b0, p_q}) - $signed(11'(5 * FRAC_BITS));
    de = -e;
    if (e >= 0) begin
      k = e >>> 1;
    end else if (!de[0]) begin
      k = pw_q ? -(de >>> 1) : -(de >>> 1) + 11'sd1;
    end else begin
      k = -(de >>> 1);
    end
    lg = 11'sd2 + k;
    if (lg < 0) lg = '0;
    if (lg > $signed(11'(LOG_FREQ_MAX))) lg = $signed(11'(LOG_FREQ_MAX));
    freq_new = zero_q ? 9'd1 : 9'(32'd1 << lg);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= F_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (phase_q == F_OUT);
      unique case (phase_q)
        F_IDLE: begin
          if (start_i) begin
            phase_q <= F_SQ;
            cnt_q   <= '0;
          end
        end
        F_SQ: begin
          if (cnt_q == 3'd3) begin
            phase_q <= F_QD;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        F_QD: begin
          if (cnt_q == 3'd3) begin
            phase_q <= F_SCAN;
            cnt_q   <= 3'd4;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        F_SCAN: begin
          cnt_q <= cnt_q - 3'd1;
          if (word != '0 || cnt_q == 3'd0) phase_q <= F_OUT;
        end
        F_OUT: begin
          phase_q <= F_IDLE;
        end
        default: phase_q <= F_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (phase_q)
      F_IDLE: begin
        if (start_i) begin
          s_q  <= sum_i;
          dt_q <= dt_i;
          sq_q <= '0;
          q_q  <= '0;
          pw_q <= $onehot(sum_i) && $onehot(dt_i);
        end
      end
      F_SQ: sq_q <= sq_q + pp_s_sh;
      F_QD: q_q  <= q_q + pp_d_sh;
      F_SCAN: begin
        p_q    <= {cnt_q, msb};
        zero_q <= (word == '0);
      end
      F_OUT: freq_q <= freq_new;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign freq_o = freq_q;

endmodule
